FILE: rtl/core/datagram_rate_limit_round_robin_unit_defines.svh
// Assertion macros shared by the rate limiter RTL.
// Depends on nothing; included by the modules that assert.
`ifndef DATAGRAM_RATE_LIMIT_ROUND_ROBIN_UNIT_DEFINES_SVH
`define DATAGRAM_RATE_LIMIT_ROUND_ROBIN_UNIT_DEFINES_SVH

// same-cycle implication
`define DRLRR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DRLRR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/drlrr_pkg.sv
// Types, sizes and register indexes of the datagram rate limiter.
// Depends on nothing; used by every module of the block.
package drlrr_pkg;

   localparam int MAX_WINDOW_COUNT = 16;
   localparam int MAX_DESTINATIONS = 16;

   localparam int TIME_W     = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int WCOUNT_W   = 5;
   localparam int DCOUNT_W   = 5;
   localparam int DEST_W     = 4;

   localparam int WCNT_W = ($clog2(MAX_WINDOW_COUNT + 1) > WCOUNT_W) ?
                           $clog2(MAX_WINDOW_COUNT + 1) : WCOUNT_W;
   localparam int SLOT_W = (MAX_WINDOW_COUNT > 1) ? $clog2(MAX_WINDOW_COUNT) : 1;
   localparam int DCNT_W = ($clog2(MAX_DESTINATIONS + 1) > DCOUNT_W) ?
                           $clog2(MAX_DESTINATIONS + 1) : DCOUNT_W;
   localparam int DIDX_W = (MAX_DESTINATIONS > 1) ? $clog2(MAX_DESTINATIONS) : 1;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_COUNT      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_TICKS      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DESTINATION_COUNT = 2'd2;

   localparam logic [WCOUNT_W-1:0] WINDOW_COUNT_RESET      = 5'd16;
   localparam logic [TIME_W-1:0]   WINDOW_TICKS_RESET      = 32'd1000000;
   localparam logic [DCOUNT_W-1:0] DESTINATION_COUNT_RESET = 5'd1;

   typedef struct packed {
      logic              accepted;
      logic [DEST_W-1:0] destination;
   } rsp_type;

endpackage

FILE: rtl/core/drlrr_front.sv
// Front end: two-entry arrival queue that takes datagram transactions.
// Depends on drlrr_pkg; feeds drlrr_back.
`include "datagram_rate_limit_round_robin_unit_defines.svh"

module drlrr_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [drlrr_pkg::TIME_W-1:0] req_arrival_time,
   output logic                        item_valid,
   output logic [drlrr_pkg::TIME_W-1:0] item_time,
   input  logic                        item_take
);

   logic [drlrr_pkg::TIME_W-1:0] data_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign req_full   = (count_ff == 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item_time  = data_ff[rd_ptr_ff];
   assign do_push    = req_push && !req_full;
   assign do_pop     = item_take && item_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= req_arrival_time;
      end
   end

   `DRLRR_ASSERT_NOW(a_front_count, clock, reset, 1'b1, count_ff <= 2'd2, "arrival queue overfilled")
   `DRLRR_ASSERT_NEXT(a_front_push, clock, reset, do_push, item_valid, "pushed arrival lost")
   `DRLRR_ASSERT_NOW(a_front_ptr, clock, reset, count_ff == 2'd0 || count_ff == 2'd2, wr_ptr_ff == rd_ptr_ff, "arrival queue pointers out of step")

endmodule

FILE: rtl/core/drlrr_back.sv
// Back end: configuration registers, arrival-time log ring and round-robin
// destination pointer; one decision per cycle while the result queue has room. Depends on drlrr_pkg.
`include "datagram_rate_limit_round_robin_unit_defines.svh"

module drlrr_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [drlrr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [drlrr_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            item_valid,
   input  logic [drlrr_pkg::TIME_W-1:0]     item_time,
   output logic                            item_take,
   input  logic                            rsp_ready,
   output logic                            rsp_push,
   output drlrr_pkg::rsp_type              rsp_data
);

   localparam int WCNT_W = drlrr_pkg::WCNT_W;
   localparam int SLOT_W = drlrr_pkg::SLOT_W;
   localparam int DCNT_W = drlrr_pkg::DCNT_W;
   localparam int DIDX_W = drlrr_pkg::DIDX_W;
   localparam logic [WCNT_W-1:0] WIN_MAX  = WCNT_W'(drlrr_pkg::MAX_WINDOW_COUNT);
   localparam logic [DCNT_W-1:0] DEST_MAX = DCNT_W'(drlrr_pkg::MAX_DESTINATIONS);

   logic [drlrr_pkg::WCOUNT_W-1:0] win_count_ff, win_count_in;
   logic [drlrr_pkg::TIME_W-1:0]   win_ticks_ff, win_ticks_in;
   logic [drlrr_pkg::DCOUNT_W-1:0] dest_count_ff, dest_count_in;

   logic [drlrr_pkg::TIME_W-1:0] kept_ff [drlrr_pkg::MAX_WINDOW_COUNT];
   logic [WCNT_W-1:0] filled_ff, filled_in;
   logic [SLOT_W-1:0] oldest_ff, oldest_in;
   logic [DIDX_W-1:0] next_dest_ff, next_dest_in;

   logic [WCNT_W-1:0] win_raw, wc_eff, slot_inc;
   logic [DCNT_W-1:0] dest_raw, dc_eff, dest_inc;
   logic              fire, log_full, too_soon, accept;
   logic [SLOT_W-1:0] slot, slot_next, wr_idx;
   logic [DIDX_W-1:0] dest_cur, dest_next;
   logic [drlrr_pkg::TIME_W-1:0] elapsed;

   assign fire      = item_valid && rsp_ready;
   assign item_take = fire;
   assign rsp_push  = fire;

   always_comb begin
      win_raw  = WCNT_W'(win_count_ff);
      dest_raw = DCNT_W'(dest_count_ff);
      wc_eff   = win_raw;
      dc_eff   = dest_raw;
      priority if (win_raw == '0) begin
         wc_eff = WCNT_W'(1);
      end else if (win_raw > WIN_MAX) begin
         wc_eff = WIN_MAX;
      end else begin
         wc_eff = win_raw;
      end
      priority if (dest_raw == '0) begin
         dc_eff = DCNT_W'(1);
      end else if (dest_raw > DEST_MAX) begin
         dc_eff = DEST_MAX;
      end else begin
         dc_eff = dest_raw;
      end

      log_full  = (filled_ff >= wc_eff);
      slot      = (WCNT_W'(oldest_ff) >= wc_eff) ? '0 : oldest_ff;
      elapsed   = item_time - kept_ff[slot];
      too_soon  = (elapsed < win_ticks_ff);
      accept    = !log_full || !too_soon;
      slot_inc  = WCNT_W'(slot) + WCNT_W'(1);
      slot_next = (slot_inc >= wc_eff) ? '0 : slot_inc[SLOT_W-1:0];
      wr_idx    = log_full ? slot : filled_ff[SLOT_W-1:0];

      dest_cur  = (DCNT_W'(next_dest_ff) >= dc_eff) ? '0 : next_dest_ff;
      dest_inc  = DCNT_W'(dest_cur) + DCNT_W'(1);
      dest_next = (dest_inc >= dc_eff) ? '0 : dest_inc[DIDX_W-1:0];

      rsp_data.accepted    = accept;
      rsp_data.destination = accept ? drlrr_pkg::DEST_W'(dest_cur) : '0;

      filled_in     = filled_ff;
      oldest_in     = oldest_ff;
      next_dest_in  = next_dest_ff;
      win_count_in  = win_count_ff;
      win_ticks_in  = win_ticks_ff;
      dest_count_in = dest_count_ff;

      if (fire) begin
         if (log_full) begin
            oldest_in = accept ? slot_next : slot;
         end else begin
            filled_in = filled_ff + WCNT_W'(1);
         end
         if (accept) begin
            next_dest_in = dest_next;
         end
      end

      if (csr_wr_en) begin
         unique case (csr_index)
            drlrr_pkg::CSR_WINDOW_COUNT: begin
               win_count_in = csr_wdata[drlrr_pkg::WCOUNT_W-1:0];
               filled_in    = '0;
               oldest_in    = '0;
            end
            drlrr_pkg::CSR_WINDOW_TICKS: begin
               win_ticks_in = csr_wdata[drlrr_pkg::TIME_W-1:0];
            end
            drlrr_pkg::CSR_DESTINATION_COUNT: begin
               dest_count_in = csr_wdata[drlrr_pkg::DCOUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_count_ff  <= drlrr_pkg::WINDOW_COUNT_RESET;
         win_ticks_ff  <= drlrr_pkg::WINDOW_TICKS_RESET;
         dest_count_ff <= drlrr_pkg::DESTINATION_COUNT_RESET;
         filled_ff     <= '0;
         oldest_ff     <= '0;
         next_dest_ff  <= '0;
      end else begin
         win_count_ff  <= win_count_in;
         win_ticks_ff  <= win_ticks_in;
         dest_count_ff <= dest_count_in;
         filled_ff     <= filled_in;
         oldest_ff     <= oldest_in;
         next_dest_ff  <= next_dest_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && accept) begin
         kept_ff[wr_idx] <= item_time;
      end
   end

   `DRLRR_ASSERT_NOW(a_back_fill, clock, reset, 1'b1, filled_ff <= wc_eff,
      "log fill count beyond window count")
   `DRLRR_ASSERT_NEXT(a_back_restart, clock, reset,
      csr_wr_en && csr_index == drlrr_pkg::CSR_WINDOW_COUNT,
      filled_ff == '0 && oldest_ff == '0, "log not restarted on window count write")
   `DRLRR_ASSERT_NOW(a_back_drop, clock, reset, rsp_push && !rsp_data.accepted,
      rsp_data.destination == '0 && log_full, "bad dropped transaction")

endmodule

FILE: rtl/core/drlrr_rsp_queue.sv
// Two-entry result queue between the decision stage and the result port.
// Depends on drlrr_pkg.
`include "datagram_rate_limit_round_robin_unit_defines.svh"

module drlrr_rsp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  drlrr_pkg::rsp_type push_data,
   output logic               ready,
   output logic               empty,
   input  logic               pop,
   output drlrr_pkg::rsp_type head
);

   drlrr_pkg::rsp_type data_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign ready   = (count_ff != 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign head    = data_ff[rd_ptr_ff];
   assign do_push = push && ready;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

   `DRLRR_ASSERT_NOW(a_rsp_push, clock, reset, push, ready, "result pushed into full queue")
   `DRLRR_ASSERT_NEXT(a_rsp_hold, clock, reset, do_push, !empty, "result transaction lost")
   `DRLRR_ASSERT_NOW(a_rsp_ptr, clock, reset, count_ff == 2'd0 || count_ff == 2'd2, wr_ptr_ff == rd_ptr_ff, "result queue pointers out of step")

endmodule

FILE: rtl/core/datagram_rate_limit_round_robin_unit.sv
// Top level of the datagram rate limiter with round-robin forwarding.
// Depends on drlrr_pkg, drlrr_front, drlrr_back and drlrr_rsp_queue.
//
// One datagram arrival transaction is taken per clock while req_full is low
// and yields one result transaction. A pushed arrival sits in a two-entry
// queue, is decided by a single read of the arrival-time log ring, one
// wrapping subtract and compare, and, if accepted, one ring write, and is
// registered in the two-entry result queue before it reaches the result
// ports; one result per cycle sustained while pop keeps up. The log needs
// no clearing pass after reset. Write configuration only while no transaction is in flight.
module datagram_rate_limit_round_robin_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [drlrr_pkg::TIME_W-1:0]      req_arrival_time,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic                             rsp_accepted,
   output logic [drlrr_pkg::DEST_W-1:0]      rsp_destination,
   input  logic                             csr_wr_en,
   input  logic [drlrr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [drlrr_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic                         item_valid;
   logic [drlrr_pkg::TIME_W-1:0] item_time;
   logic                         item_take;
   logic                         rsp_ready;
   logic                         rsp_push;
   drlrr_pkg::rsp_type           rsp_data;
   drlrr_pkg::rsp_type           rsp_head;

   drlrr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_arrival_time (req_arrival_time),
      .item_valid       (item_valid),
      .item_time        (item_time),
      .item_take        (item_take)
   );

   drlrr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .item_valid (item_valid),
      .item_time  (item_time),
      .item_take  (item_take),
      .rsp_ready  (rsp_ready),
      .rsp_push   (rsp_push),
      .rsp_data   (rsp_data)
   );

   drlrr_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_data),
      .ready     (rsp_ready),
      .empty     (rsp_empty),
      .pop       (rsp_pop),
      .head      (rsp_head)
   );

   assign rsp_accepted    = rsp_head.accepted;
   assign rsp_destination = rsp_head.destination;

endmodule
